// File: rtl/core/fuzzy_speed_angle_power_controller_core_defines.svh
// Assertion macros shared by the fuzzy power controller RTL.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef FUZZY_SPEED_ANGLE_POWER_CONTROLLER_CORE_DEFINES_SVH
`define FUZZY_SPEED_ANGLE_POWER_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define FSPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FSPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fspc_pkg.sv
// Shared types and constants of the fuzzy power controller.
// No dependencies; used by every module of the block.
`default_nettype none

package fspc_pkg;

    // Field widths fixed by the stream format
    localparam int SPEED_W    = 12;
    localparam int ANGLE_W    = 13;
    localparam int CENTER_W   = 10;
    localparam int STRENGTH_W = 9;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    // Configuration register map
    localparam int                CFG_INDEX_W       = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_MEDIUM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_HIGH   = 2'd2;

    localparam logic [CENTER_W-1:0] CENTER_LOW_RST    = 10'd300;
    localparam logic [CENTER_W-1:0] CENTER_MEDIUM_RST = 10'd500;
    localparam logic [CENTER_W-1:0] CENTER_HIGH_RST   = 10'd700;

    // Divide by three: floor(x * 21846 / 2^16) is exact for x below 2^15
    localparam int              DIV3_IN_W  = 16;
    localparam logic [15:0]     DIV3_MUL   = 16'd21846;
    localparam int              DIV3_SHIFT = 16;

    // Queue between classification and defuzzification
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Output power classes
    typedef enum logic [1:0] {
        CLS_LOW,
        CLS_MEDIUM,
        CLS_HIGH
    } fspc_class_t;

    localparam int NUM_SPEED_SETS = 3;
    localparam int NUM_ANGLE_SETS = 5;
    localparam int NUM_CLASSES    = 3;

    // Rule base: rows speed low/medium/high, columns LN, SN, Z, SP, LP
    localparam fspc_class_t RULE_CLASS [NUM_SPEED_SETS][NUM_ANGLE_SETS] = '{
        '{CLS_LOW,    CLS_MEDIUM, CLS_HIGH,   CLS_MEDIUM, CLS_LOW},
        '{CLS_MEDIUM, CLS_LOW,    CLS_HIGH,   CLS_LOW,    CLS_MEDIUM},
        '{CLS_MEDIUM, CLS_LOW,    CLS_MEDIUM, CLS_LOW,    CLS_MEDIUM}
    };

endpackage

`default_nettype wire

// File: rtl/core/fspc_front.sv
// Front end: grades speed and angle by trapezoid sets, then applies the
// min/max rule base. Depends on fspc_pkg.
`default_nettype none

module fspc_front #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    input  wire logic [fspc_pkg::SPEED_W-1:0]          speed_in,
    input  wire logic signed [fspc_pkg::ANGLE_W-1:0]   angle_in,
    input  wire logic                                  q_full,
    output      logic                                  q_push,
    output      logic [fspc_pkg::NUM_CLASSES*(FRAC_BITS+1)-1:0] q_data
);

    localparam int MW    = FRAC_BITS + 1;
    localparam int IW    = (FRAC_BITS + 6 > 16) ? FRAC_BITS + 6 : 16;
    localparam int ONE_I = 1 << FRAC_BITS;

    localparam logic signed [IW-1:0] ZERO = '0;
    localparam logic signed [IW-1:0] U2   = IW'(2 * ONE_I);
    localparam logic signed [IW-1:0] U3   = IW'(3 * ONE_I);
    localparam logic signed [IW-1:0] U5   = IW'(5 * ONE_I);
    localparam logic signed [IW-1:0] U6   = IW'(6 * ONE_I);
    localparam logic signed [IW-1:0] U8   = IW'(8 * ONE_I);
    localparam logic signed [IW-1:0] U9   = IW'(9 * ONE_I);
    localparam logic signed [IW-1:0] UM2  = IW'(-2 * ONE_I);
    localparam logic signed [IW-1:0] UM5  = IW'(-5 * ONE_I);
    localparam logic [MW-1:0]        ONE  = MW'(ONE_I);

    // Nonnegative value below 3.0 divided by three, truncated
    function automatic logic [MW-1:0] div3(input logic signed [IW-1:0] x);
        logic [2*fspc_pkg::DIV3_IN_W-1:0] prod;
        prod = x[fspc_pkg::DIV3_IN_W-1:0] * fspc_pkg::DIV3_MUL;
        return MW'(prod >> fspc_pkg::DIV3_SHIFT);
    endfunction

    function automatic logic [MW-1:0] half(input logic signed [IW-1:0] x);
        return MW'(x >>> 1);
    endfunction

    logic signed [IW-1:0] s;
    logic signed [IW-1:0] a;
    logic [MW-1:0] ms_next [fspc_pkg::NUM_SPEED_SETS];
    logic [MW-1:0] ma_next [fspc_pkg::NUM_ANGLE_SETS];
    logic [MW-1:0] ms_reg  [fspc_pkg::NUM_SPEED_SETS];
    logic [MW-1:0] ma_reg  [fspc_pkg::NUM_ANGLE_SETS];
    logic          f1_valid_reg;
    logic          f1_valid_next;
    logic          f1_adv;
    logic [MW-1:0] cls    [fspc_pkg::NUM_CLASSES];

    assign s = $signed(IW'(speed_in));
    assign a = IW'(angle_in);

    // Speed memberships: low, medium, high
    always_comb begin
        if (s <= U3) begin
            ms_next[0] = ONE;
        end else if (s < U6) begin
            ms_next[0] = div3(U6 - s);
        end else begin
            ms_next[0] = '0;
        end

        if (s <= U3) begin
            ms_next[1] = '0;
        end else if (s < U6) begin
            ms_next[1] = div3(s - U3);
        end else if (s <= U8) begin
            ms_next[1] = ONE;
        end else if (s < U9) begin
            ms_next[1] = MW'(U9 - s);
        end else begin
            ms_next[1] = '0;
        end

        if (s <= U8) begin
            ms_next[2] = '0;
        end else if (s < U9) begin
            ms_next[2] = MW'(s - U8);
        end else begin
            ms_next[2] = ONE;
        end
    end

    // Angle memberships: LN, SN, Z, SP, LP
    always_comb begin
        if (a <= UM5) begin
            ma_next[0] = ONE;
        end else if (a < UM2) begin
            ma_next[0] = div3(-a - U2);
        end else begin
            ma_next[0] = '0;
        end

        if (a <= UM5) begin
            ma_next[1] = '0;
        end else if (a <= UM2) begin
            ma_next[1] = div3(a + U5);
        end else if (a < ZERO) begin
            ma_next[1] = half(-a);
        end else begin
            ma_next[1] = '0;
        end

        if (a <= UM2) begin
            ma_next[2] = '0;
        end else if (a <= ZERO) begin
            ma_next[2] = half(a + U2);
        end else if (a < U2) begin
            ma_next[2] = half(U2 - a);
        end else begin
            ma_next[2] = '0;
        end

        if (a <= ZERO) begin
            ma_next[3] = '0;
        end else if (a <= U2) begin
            ma_next[3] = half(a);
        end else if (a < U5) begin
            ma_next[3] = div3(U5 - a);
        end else begin
            ma_next[3] = '0;
        end

        if (a <= U2) begin
            ma_next[4] = '0;
        end else if (a < U5) begin
            ma_next[4] = div3(a - U2);
        end else begin
            ma_next[4] = ONE;
        end
    end

    // Grade stage advances unless its item is blocked by a full queue
    assign f1_adv        = !f1_valid_reg || !q_full;
    assign s_tready      = f1_adv;
    assign f1_valid_next = f1_adv ? s_tvalid : f1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_adv && s_tvalid) begin
            ms_reg <= ms_next;
            ma_reg <= ma_next;
        end
    end

    // Rule base: min of the two grades, max over the rules of each class
    always_comb begin
        logic [MW-1:0] rmin;
        for (int c = 0; c < fspc_pkg::NUM_CLASSES; c++) begin
            cls[c] = '0;
            for (int i = 0; i < fspc_pkg::NUM_SPEED_SETS; i++) begin
                for (int j = 0; j < fspc_pkg::NUM_ANGLE_SETS; j++) begin
                    rmin = (ms_reg[i] < ma_reg[j]) ? ms_reg[i] : ma_reg[j];
                    if (int'(fspc_pkg::RULE_CLASS[i][j]) == c && rmin > cls[c]) begin
                        cls[c] = rmin;
                    end
                end
            end
        end
    end

    assign q_push = f1_valid_reg && !q_full;
    assign q_data = {cls[2], cls[1], cls[0]};

endmodule

`default_nettype wire

// File: rtl/core/fspc_queue.sv
// Short first-in first-out queue of class strengths between the front end
// and the defuzzifier. Depends on fspc_pkg.
`default_nettype none

module fspc_queue #(
    parameter int WIDTH = 27
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             full,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]                   slot_reg [fspc_pkg::QUEUE_DEPTH];
    logic [fspc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [fspc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [fspc_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                               pop;

    assign full      = count_reg == fspc_pkg::QUEUE_CNT_W'(fspc_pkg::QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fspc_back.sv
// Back end: weights the class strengths by the centers, picks the strongest
// class and divides with a pipelined restoring divider. Depends on fspc_pkg.
`default_nettype none

module fspc_back #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   q_valid,
    output      logic                                   q_ready,
    input  wire logic [fspc_pkg::NUM_CLASSES*(FRAC_BITS+1)-1:0] q_data,
    input  wire logic [fspc_pkg::CENTER_W-1:0]          center_low,
    input  wire logic [fspc_pkg::CENTER_W-1:0]          center_medium,
    input  wire logic [fspc_pkg::CENTER_W-1:0]          center_high,
    output      logic                                   m_valid,
    input  wire logic                                   m_ready,
    output      logic [fspc_pkg::STRENGTH_W-1:0]        strength_low,
    output      logic [fspc_pkg::STRENGTH_W-1:0]        strength_medium,
    output      logic [fspc_pkg::STRENGTH_W-1:0]        strength_high,
    output      logic [fspc_pkg::CENTER_W-1:0]          power_mean_max,
    output      logic [fspc_pkg::CENTER_W-1:0]          power_weighted,
    output      logic                                   nothing_fired
);

    localparam int MW  = FRAC_BITS + 1;
    localparam int QW  = fspc_pkg::CENTER_W;
    localparam int PW  = QW + MW;
    localparam int NW  = PW + 2;
    localparam int DW  = MW + 2;
    localparam int CW  = fspc_pkg::NUM_CLASSES * MW;
    localparam int SBW = CW + QW + 1;

    logic          adv;

    // Product stage
    logic          b0_valid_reg;
    logic [PW-1:0] prod_reg [fspc_pkg::NUM_CLASSES];
    logic [CW-1:0] b0_cls_reg;
    logic [MW-1:0] c_low, c_med, c_high;

    // Sum and select, feeding divider stage zero
    logic [NW-1:0] num_next;
    logic [DW-1:0] den_next;
    logic [QW-1:0] mean_next;
    logic          none_next;
    logic [MW-1:0] best_val;
    logic [QW-1:0] best_ctr;

    // Divider stages: sideband holds strengths, mean-of-max and the empty flag
    logic [QW:0]    dv_valid_reg;
    logic [NW-1:0]  dv_rem_reg  [QW+1];
    logic [DW-1:0]  dv_den_reg  [QW+1];
    logic [QW-1:0]  dv_q_reg    [QW+1];
    logic [SBW-1:0] dv_sb_reg   [QW+1];
    logic [NW-1:0]  dv_rem_next [QW];
    logic [QW-1:0]  dv_q_next   [QW];

    // Output register
    logic           m_valid_reg;
    logic [CW-1:0]  out_cls_reg;
    logic [QW-1:0]  out_mean_reg;
    logic [QW-1:0]  out_wavg_reg;
    logic           out_none_reg;
    logic [SBW-1:0] last_sb;

    // Whole back pipeline moves together while the output slot can take an item
    assign adv     = !m_valid_reg || m_ready;
    assign q_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            b0_valid_reg <= q_valid;
            dv_valid_reg <= {dv_valid_reg[QW-1:0], b0_valid_reg};
            m_valid_reg  <= dv_valid_reg[QW];
        end
    end

    // Weight each strength by its center
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg[0] <= PW'(center_low    * q_data[0*MW +: MW]);
            prod_reg[1] <= PW'(center_medium * q_data[1*MW +: MW]);
            prod_reg[2] <= PW'(center_high   * q_data[2*MW +: MW]);
            b0_cls_reg  <= q_data;
        end
    end

    assign c_low  = b0_cls_reg[0*MW +: MW];
    assign c_med  = b0_cls_reg[1*MW +: MW];
    assign c_high = b0_cls_reg[2*MW +: MW];

    // Sum numerator and denominator; pick strongest class, lower one on ties
    always_comb begin
        num_next  = NW'(prod_reg[0]) + NW'(prod_reg[1]) + NW'(prod_reg[2]);
        den_next  = DW'(c_low) + DW'(c_med) + DW'(c_high);
        none_next = den_next == '0;
        if (c_med > c_low) begin
            best_val = c_med;
            best_ctr = center_medium;
        end else begin
            best_val = c_low;
            best_ctr = center_low;
        end
        if (c_high > best_val) begin
            best_ctr = center_high;
        end
        mean_next = none_next ? '0 : best_ctr;
    end

    // One quotient bit per stage, most significant first
    always_comb begin
        logic [NW-1:0] trial;
        for (int i = 0; i < QW; i++) begin
            trial = NW'(dv_den_reg[i]) << (QW - 1 - i);
            if (dv_rem_reg[i] >= trial) begin
                dv_rem_next[i] = dv_rem_reg[i] - trial;
                dv_q_next[i]   = dv_q_reg[i] | (QW'(1) << (QW - 1 - i));
            end else begin
                dv_rem_next[i] = dv_rem_reg[i];
                dv_q_next[i]   = dv_q_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0] <= num_next;
            dv_den_reg[0] <= den_next;
            dv_q_reg[0]   <= '0;
            dv_sb_reg[0]  <= {none_next, mean_next, b0_cls_reg};
            for (int i = 0; i < QW; i++) begin
                dv_rem_reg[i+1] <= dv_rem_next[i];
                dv_den_reg[i+1] <= dv_den_reg[i];
                dv_q_reg[i+1]   <= dv_q_next[i];
                dv_sb_reg[i+1]  <= dv_sb_reg[i];
            end
        end
    end

    // Load the output slot; zero the average when nothing fired
    assign last_sb = dv_sb_reg[QW];

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_cls_reg  <= last_sb[CW-1:0];
            out_mean_reg <= last_sb[CW +: QW];
            out_none_reg <= last_sb[SBW-1];
            out_wavg_reg <= last_sb[SBW-1] ? '0 : dv_q_reg[QW];
        end
    end

    assign m_valid         = m_valid_reg;
    assign strength_low    = fspc_pkg::STRENGTH_W'(out_cls_reg[0*MW +: MW]);
    assign strength_medium = fspc_pkg::STRENGTH_W'(out_cls_reg[1*MW +: MW]);
    assign strength_high   = fspc_pkg::STRENGTH_W'(out_cls_reg[2*MW +: MW]);
    assign power_mean_max  = out_mean_reg;
    assign power_weighted  = out_wavg_reg;
    assign nothing_fired   = out_none_reg;

endmodule

`default_nettype wire

// File: rtl/core/fuzzy_speed_angle_power_controller_core.sv
// Top level of the fuzzy speed/angle power controller: configuration
// registers, front end, queue and back end. Depends on fspc_pkg and the defines.
//
//   Channel  Dir  Payload
//   s_       in   speed_in, angle_in
//   m_       out  strengths, mean-of-max power, weighted power, nothing_fired
//   cfg_     in   center_low, center_medium, center_high
//
// One item per cycle sustained while m_tready stays high. A result is offered
// once its item has passed the grade register, queue slot, product stage,
// QW + 1 restoring divider stages and the output register.
// A four-entry queue lets the front keep accepting while the output stalls.
// Reset is synchronous, active low, and restores the default centers.
`default_nettype none
`include "fuzzy_speed_angle_power_controller_core_defines.svh"

module fuzzy_speed_angle_power_controller_core #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output      logic                                  s_tready,
    // [11:0] speed_in, [24:12] angle_in, [31:25] zero
    input  wire logic [fspc_pkg::S_TDATA_W-1:0]        s_tdata,
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    // [8:0] strength_low, [17:9] strength_medium, [26:18] strength_high,
    // [36:27] power_mean_max, [46:37] power_weighted, [47] nothing_fired
    output      logic [fspc_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [fspc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [fspc_pkg::CENTER_W-1:0]         cfg_wdata
);

    localparam int MW = FRAC_BITS + 1;
    localparam int CW = fspc_pkg::NUM_CLASSES * MW;

    logic [fspc_pkg::CENTER_W-1:0] center_low_reg, center_low_next;
    logic [fspc_pkg::CENTER_W-1:0] center_medium_reg, center_medium_next;
    logic [fspc_pkg::CENTER_W-1:0] center_high_reg, center_high_next;

    logic          q_push;
    logic          q_full;
    logic [CW-1:0] q_push_data;
    logic          q_valid;
    logic          q_ready;
    logic [CW-1:0] q_pop_data;

    logic [fspc_pkg::STRENGTH_W-1:0] strength_low;
    logic [fspc_pkg::STRENGTH_W-1:0] strength_medium;
    logic [fspc_pkg::STRENGTH_W-1:0] strength_high;
    logic [fspc_pkg::CENTER_W-1:0]   power_mean_max;
    logic [fspc_pkg::CENTER_W-1:0]   power_weighted;
    logic                            nothing_fired;

    // Decode configuration writes; unmapped indexes are dropped
    always_comb begin
        center_low_next    = center_low_reg;
        center_medium_next = center_medium_reg;
        center_high_next   = center_high_reg;
        if (cfg_we) begin
            case (cfg_index)
                fspc_pkg::CFG_CENTER_LOW:    center_low_next    = cfg_wdata;
                fspc_pkg::CFG_CENTER_MEDIUM: center_medium_next = cfg_wdata;
                fspc_pkg::CFG_CENTER_HIGH:   center_high_next   = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_low_reg    <= fspc_pkg::CENTER_LOW_RST;
            center_medium_reg <= fspc_pkg::CENTER_MEDIUM_RST;
            center_high_reg   <= fspc_pkg::CENTER_HIGH_RST;
        end else begin
            center_low_reg    <= center_low_next;
            center_medium_reg <= center_medium_next;
            center_high_reg   <= center_high_next;
        end
    end

    fspc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .speed_in (s_tdata[fspc_pkg::SPEED_W-1:0]),
        .angle_in ($signed(s_tdata[fspc_pkg::SPEED_W +: fspc_pkg::ANGLE_W])),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    fspc_queue #(
        .WIDTH (CW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_pop_data)
    );

    fspc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_data          (q_pop_data),
        .center_low      (center_low_reg),
        .center_medium   (center_medium_reg),
        .center_high     (center_high_reg),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .strength_low    (strength_low),
        .strength_medium (strength_medium),
        .strength_high   (strength_high),
        .power_mean_max  (power_mean_max),
        .power_weighted  (power_weighted),
        .nothing_fired   (nothing_fired)
    );

    // Pack the result item, first field lowest
    assign m_tdata = {nothing_fired, power_weighted, power_mean_max,
                      strength_high, strength_medium, strength_low};

    // Front never pushes into a full queue
    `FSPC_ASSERT_IMP(a_no_push_when_full, q_push, !q_full, "push into full queue")

    // An empty rule firing gives zero strengths and zero powers
    `FSPC_ASSERT_IMP(a_none_zeroes, m_tvalid && nothing_fired,
        strength_low == '0 && strength_medium == '0 && strength_high == '0 &&
        power_mean_max == '0 && power_weighted == '0, "nothing fired but fields set")

    // Mean-of-max is always one of the configured centers when a rule fired
    `FSPC_ASSERT_IMP(a_mean_is_center, m_tvalid && !nothing_fired,
        power_mean_max == center_low_reg || power_mean_max == center_medium_reg ||
        power_mean_max == center_high_reg, "mean-of-max not a center")

endmodule

`default_nettype wire

// File: tb/sv/fuzzy_speed_angle_power_controller_core_tb.sv
// Self-checking testbench for the fuzzy speed/angle power controller core.
// Predicts class strengths and both power outputs per sample; depends on fspc_pkg
// and the core RTL only.
module fuzzy_speed_angle_power_controller_core_tb;

    localparam int FRAC_BITS    = 8;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int HALF_PERIOD  = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 30;
    localparam int SHOW_LIMIT   = 10;

    // Index outside the register map; writes to it must change nothing
    localparam logic [fspc_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Result item as packed on m_tdata, most significant field first
    typedef struct packed {
        logic                            nothing_fired;
        logic [fspc_pkg::CENTER_W-1:0]   power_weighted;
        logic [fspc_pkg::CENTER_W-1:0]   power_mean_max;
        logic [fspc_pkg::STRENGTH_W-1:0] strength_high;
        logic [fspc_pkg::STRENGTH_W-1:0] strength_medium;
        logic [fspc_pkg::STRENGTH_W-1:0] strength_low;
    } power_result_t;

    // Rule base: rows speed low/medium/high, columns LN, SN, Z, SP, LP
    localparam fspc_pkg::fspc_class_t CLASS_OF_RULE
        [fspc_pkg::NUM_SPEED_SETS][fspc_pkg::NUM_ANGLE_SETS] = '{
        '{fspc_pkg::CLS_LOW,    fspc_pkg::CLS_MEDIUM, fspc_pkg::CLS_HIGH,
          fspc_pkg::CLS_MEDIUM, fspc_pkg::CLS_LOW},
        '{fspc_pkg::CLS_MEDIUM, fspc_pkg::CLS_LOW,    fspc_pkg::CLS_HIGH,
          fspc_pkg::CLS_LOW,    fspc_pkg::CLS_MEDIUM},
        '{fspc_pkg::CLS_MEDIUM, fspc_pkg::CLS_LOW,    fspc_pkg::CLS_MEDIUM,
          fspc_pkg::CLS_LOW,    fspc_pkg::CLS_MEDIUM}
    };

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    // [11:0] speed_in, [24:12] angle_in, [31:25] zero
    logic [fspc_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // [8:0] strength_low, [17:9] strength_medium, [26:18] strength_high,
    // [36:27] power_mean_max, [46:37] power_weighted, [47] nothing_fired
    logic [fspc_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_we    = 1'b0;
    logic [fspc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [fspc_pkg::CENTER_W-1:0]    cfg_wdata = '0;

    // Center registers as the block should hold them
    logic [fspc_pkg::CENTER_W-1:0] center_model [fspc_pkg::NUM_CLASSES];

    power_result_t expected_power [$];
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    bit hold_request      = 1'b0;
    int samples_accepted  = 0;
    int results_checked   = 0;
    int center_settings   = 1;
    int error_count       = 0;
    int shown_count       = 0;
    int quiet_cycles      = 0;

    fuzzy_speed_angle_power_controller_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Grade the sample, fire the rules and defuzzify against the model centers
    function automatic power_result_t predict_power(
        input logic [fspc_pkg::SPEED_W-1:0]        speed,
        input logic signed [fspc_pkg::ANGLE_W-1:0] angle
    );
        int                    s;
        int                    a;
        int                    sg [fspc_pkg::NUM_SPEED_SETS];
        int                    ag [fspc_pkg::NUM_ANGLE_SETS];
        int                    strength [fspc_pkg::NUM_CLASSES];
        int                    grade;
        int                    best;
        longint                num;
        longint                den;
        fspc_pkg::fspc_class_t cls;
        power_result_t         r;
        s = speed;
        a = angle;

        sg[0] = (s <= 3*ONE) ? ONE : (s < 6*ONE) ? (6*ONE - s) / 3 : 0;
        sg[1] = (s <= 3*ONE) ? 0 : (s < 6*ONE) ? (s - 3*ONE) / 3 :
                (s <= 8*ONE) ? ONE : (s < 9*ONE) ? 9*ONE - s : 0;
        sg[2] = (s <= 8*ONE) ? 0 : (s < 9*ONE) ? s - 8*ONE : ONE;

        ag[0] = (a <= -5*ONE) ? ONE : (a < -2*ONE) ? (-a - 2*ONE) / 3 : 0;
        ag[1] = (a <= -5*ONE) ? 0 : (a <= -2*ONE) ? (a + 5*ONE) / 3 :
                (a < 0) ? (-a) / 2 : 0;
        ag[2] = (a <= -2*ONE) ? 0 : (a <= 0) ? (a + 2*ONE) / 2 :
                (a < 2*ONE) ? (2*ONE - a) / 2 : 0;
        ag[3] = (a <= 0) ? 0 : (a <= 2*ONE) ? a / 2 :
                (a < 5*ONE) ? (5*ONE - a) / 3 : 0;
        ag[4] = (a <= 2*ONE) ? 0 : (a < 5*ONE) ? (a - 2*ONE) / 3 : ONE;

        // Min per rule, max per class
        for (int k = 0; k < fspc_pkg::NUM_CLASSES; k++) strength[k] = 0;
        for (int i = 0; i < fspc_pkg::NUM_SPEED_SETS; i++) begin
            for (int j = 0; j < fspc_pkg::NUM_ANGLE_SETS; j++) begin
                cls   = CLASS_OF_RULE[i][j];
                grade = (sg[i] < ag[j]) ? sg[i] : ag[j];
                if (grade > strength[int'(cls)]) strength[int'(cls)] = grade;
            end
        end

        // Strongest class wins, lower class on a tie
        best = int'(fspc_pkg::CLS_LOW);
        if (strength[int'(fspc_pkg::CLS_MEDIUM)] > strength[best]) begin
            best = int'(fspc_pkg::CLS_MEDIUM);
        end
        if (strength[int'(fspc_pkg::CLS_HIGH)] > strength[best]) begin
            best = int'(fspc_pkg::CLS_HIGH);
        end

        num = 0;
        den = 0;
        for (int k = 0; k < fspc_pkg::NUM_CLASSES; k++) begin
            num += longint'(center_model[k]) * strength[k];
            den += strength[k];
        end

        r = '0;
        r.strength_low    = fspc_pkg::STRENGTH_W'(strength[int'(fspc_pkg::CLS_LOW)]);
        r.strength_medium = fspc_pkg::STRENGTH_W'(strength[int'(fspc_pkg::CLS_MEDIUM)]);
        r.strength_high   = fspc_pkg::STRENGTH_W'(strength[int'(fspc_pkg::CLS_HIGH)]);
        r.nothing_fired   = (den == 0);
        if (den != 0) begin
            r.power_mean_max = center_model[best];
            r.power_weighted = fspc_pkg::CENTER_W'(num / den);
        end
        return r;
    endfunction

    // Output side: random ready, or a long hold when one is requested
    always @(posedge aclk) begin : output_ready
        int hold_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check each result against the oldest prediction, then record new samples
    always @(posedge aclk) begin : result_check
        power_result_t got;
        power_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_checked++;
                if (expected_power.size() == 0) begin
                    error_count++;
                    if (shown_count < SHOW_LIMIT) begin
                        shown_count++;
                        $display("[%0t] unexpected result %h", $realtime, got);
                    end
                end else begin
                    want = expected_power.pop_front();
                    if (got.strength_low    !== want.strength_low    ||
                        got.strength_medium !== want.strength_medium ||
                        got.strength_high   !== want.strength_high   ||
                        got.power_mean_max  !== want.power_mean_max  ||
                        got.power_weighted  !== want.power_weighted  ||
                        got.nothing_fired   !== want.nothing_fired) begin
                        error_count++;
                        if (shown_count < SHOW_LIMIT) begin
                            shown_count++;
                            $display({"[%0t] mismatch exp: L=%0d M=%0d H=%0d",
                                      " mom=%0d wavg=%0d none=%0b"},
                                     $realtime, want.strength_low, want.strength_medium,
                                     want.strength_high, want.power_mean_max,
                                     want.power_weighted, want.nothing_fired);
                            $display({"             got: L=%0d M=%0d H=%0d",
                                      " mom=%0d wavg=%0d none=%0b"},
                                     got.strength_low, got.strength_medium,
                                     got.strength_high, got.power_mean_max,
                                     got.power_weighted, got.nothing_fired);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_power.push_back(predict_power(
                    s_tdata[fspc_pkg::SPEED_W-1:0],
                    s_tdata[fspc_pkg::SPEED_W+fspc_pkg::ANGLE_W-1:fspc_pkg::SPEED_W]));
                samples_accepted++;
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one sample, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_sample(input logic [fspc_pkg::SPEED_W-1:0]        speed,
                               input logic signed [fspc_pkg::ANGLE_W-1:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(fspc_pkg::S_TDATA_W-fspc_pkg::SPEED_W-fspc_pkg::ANGLE_W){1'b0}},
                     angle, speed};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_power.size() != 0) @(posedge aclk);
    endtask

    task automatic write_center(input logic [fspc_pkg::CFG_INDEX_W-1:0] index,
                                input logic [fspc_pkg::CENTER_W-1:0]    value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index != CFG_UNMAPPED) center_model[index] = value;
        @(posedge aclk);
    endtask

    task automatic write_centers(input logic [fspc_pkg::CENTER_W-1:0] c_low,
                                 input logic [fspc_pkg::CENTER_W-1:0] c_medium,
                                 input logic [fspc_pkg::CENTER_W-1:0] c_high);
        drain_results();
        write_center(fspc_pkg::CFG_CENTER_LOW, c_low);
        write_center(fspc_pkg::CFG_CENTER_MEDIUM, c_medium);
        write_center(fspc_pkg::CFG_CENTER_HIGH, c_high);
        center_settings++;
    endtask

    // Mostly samples around the membership breakpoints, some over the full range
    function automatic logic [fspc_pkg::SPEED_W-1:0] pick_speed();
        if ($urandom_range(99) < 70) return fspc_pkg::SPEED_W'($urandom_range(2600));
        return fspc_pkg::SPEED_W'($urandom_range(4095));
    endfunction

    function automatic logic signed [fspc_pkg::ANGLE_W-1:0] pick_angle();
        int v;
        if ($urandom_range(99) < 70) begin
            v = $urandom_range(3000);
            v = v - 1500;
        end else begin
            v = $urandom_range(8191);
        end
        return fspc_pkg::ANGLE_W'(v);
    endfunction

    task automatic random_samples(input int count);
        repeat (count) send_sample(pick_speed(), pick_angle());
    endtask

    // Field extremes, set edges on both axes and a medium/high strength tie
    task automatic test_breakpoints();
        int speeds [23] = '{0, 4095, 768, 769, 1152, 1535, 1536, 2048, 2049, 2176,
                            2303, 2304, 0, 1000, 1800, 3000, 500, 1200, 2100, 2200,
                            4095, 0, 1536};
        int angles [23] = '{-4096, 4095, -1280, -1279, -896, -513, -512, -511, -256,
                            -1, 0, 1, -256, 256, 511, 512, 513, 896, 1279, 1280,
                            -4096, 4095, 0};
        for (int k = 0; k < 23; k++) begin
            send_sample(fspc_pkg::SPEED_W'(speeds[k]), fspc_pkg::ANGLE_W'(angles[k]));
        end
    endtask

    // Centers at the ends of the register range, including above 1000
    task automatic test_center_extremes(input int count);
        write_centers('0, 10'd1000, '1);
        random_samples(count);
        write_centers('1, '0, '0);
        random_samples(count);
    endtask

    // Random centers per chunk; a write to the unmapped index must be ignored
    task automatic test_random_centers(input int chunks, input int count);
        repeat (chunks) begin
            write_centers(fspc_pkg::CENTER_W'($urandom_range(1023)),
                          fspc_pkg::CENTER_W'($urandom_range(1023)),
                          fspc_pkg::CENTER_W'($urandom_range(1023)));
            write_center(CFG_UNMAPPED, fspc_pkg::CENTER_W'($urandom_range(1023)));
            random_samples(count);
        end
    endtask

    // Hold the output long enough that the queue fills and the input stalls
    task automatic test_output_hold(input int count);
        drain_results();
        hold_request = 1'b1;
        @(posedge aclk);
        random_samples(count);
    endtask

    task automatic test_default_centers(input int count);
        write_centers(fspc_pkg::CENTER_LOW_RST, fspc_pkg::CENTER_MEDIUM_RST,
                      fspc_pkg::CENTER_HIGH_RST);
        random_samples(count);
    endtask

    initial begin
        center_model[fspc_pkg::CFG_CENTER_LOW]    = fspc_pkg::CENTER_LOW_RST;
        center_model[fspc_pkg::CFG_CENTER_MEDIUM] = fspc_pkg::CENTER_MEDIUM_RST;
        center_model[fspc_pkg::CFG_CENTER_HIGH]   = fspc_pkg::CENTER_HIGH_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 74;
        test_breakpoints();
        test_center_extremes(125);

        send_idle_pct = 74;
        recv_idle_pct = 30;
        test_random_centers(5, 50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_hold(40);
        test_default_centers(200);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        error_count += expected_power.size();

        $display("Sent %0d samples over %0d center settings, three idle profiles",
                 samples_accepted, center_settings);
        $display("and one long output hold; checked %0d results, %0d errors.",
                 results_checked, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fspc_pkg.sv
rtl/core/fspc_front.sv
rtl/core/fspc_queue.sv
rtl/core/fspc_back.sv
rtl/core/fuzzy_speed_angle_power_controller_core.sv
tb/sv/fuzzy_speed_angle_power_controller_core_tb.sv
